FILE: sv/mxp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxp_pkg
// Shared constants, types and helpers for the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
package mxp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_POOL   = 8;

  localparam int SAMPLE_W = 16;
  localparam int DIM_W    = 11;
  localparam int POOL_W   = 4;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int PH_W     = $clog2(MAX_POOL);
  localparam int CIDX_W   = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [DIM_W-1:0]           dim_t;
  typedef logic [POOL_W-1:0]          pool_t;
  typedef logic [COL_W-1:0]           col_t;
  typedef logic [ROW_W-1:0]           row_t;
  typedef logic [PH_W-1:0]            phase_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_NUM_ROWS = 2'd0,
    REG_NUM_COLS = 2'd1,
    REG_WIN_SIZE = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_idx_t;

  localparam dim_t  TOP_HEIGHT = DIM_W'(MAX_HEIGHT);
  localparam dim_t  TOP_WIDTH  = DIM_W'(MAX_WIDTH);
  localparam pool_t TOP_POOL   = POOL_W'(MAX_POOL);

  // Zero counts as one; anything above the top of the range counts as the top.
  function automatic dim_t clamp_dim(dim_t v, dim_t top);
    dim_t r;
    if (v == '0) r = DIM_W'(1);
    else if (v > top) r = top;
    else r = v;
    return r;
  endfunction

  function automatic pool_t clamp_pool(pool_t v);
    pool_t r;
    if (v == '0) r = POOL_W'(1);
    else if (v > TOP_POOL) r = TOP_POOL;
    else r = v;
    return r;
  endfunction

endpackage

FILE: sv/max_pool_2d_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Streaming 2-D max pooling over non-overlapping square windows.
// ----------------------------------------------------------------------------
// Samples of the feature map arrive in raster order on the s_* stream, one
// signed 16-bit value per transfer. Each completed window produces one
// transfer on the m_* stream carrying its maximum; m_tlast marks the last
// output of the map. Windows on the right and bottom edges may be partial.
// The cfg_* channel writes the row count (index 0), the samples per row
// (index 1) and the window side (index 2); any such write restarts the map
// at row 0, column 0. Writes to other indexes are ignored. Write
// configuration only while idle.
// Throughput is one sample per cycle unless a stalled receiver backs the
// block up; each sample that closes a window row segment does one
// read-modify-write of the column maximum line store. A sample that closes a
// window appears on m_* after the line-store read stage and then the output
// register. When the receiver stalls, the output register holds its result
// and the block keeps taking samples until the next window-closing sample
// reaches the read stage; from then on the input waits until the output register frees up.
// Reset is synchronous and returns the registers to 4 x 5 map, pool size 2,
// and clears the position counters. The line store needs no clearing: every
// entry is overwritten on the first row of its window, whatever was read.
// ----------------------------------------------------------------------------
module max_pool_2d_stream (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream: tdata = sample[15:0].
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mxp_pkg::SAMPLE_W-1:0]  s_tdata,
  // Output stream: tdata = pooled_value[15:0]; tlast = map_done.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mxp_pkg::SAMPLE_W-1:0]  m_tdata,
  output logic                          m_tlast,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mxp_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [mxp_pkg::DIM_W-1:0]     cfg_data
);

  import mxp_pkg::*;

  // Stage 1 holds a sample whose line-store read is in flight.
  typedef struct packed {
    logic    valid;
    logic    h_end;     // closes a window row segment: update the line store
    logic    emit;      // closes a whole window: produce a result
    logic    row_first; // first row of the window: overwrite the entry
    logic    last;      // last output of the map
    col_t    oc;
    sample_t run_max;
  } stage_t;

  // Configuration registers.
  dim_t  num_rows;
  dim_t  num_cols;
  pool_t win_size;

  dim_t  h_eff;
  dim_t  w_eff;
  pool_t p_eff;

  // Position state.
  row_t    row_index;
  col_t    col_index;
  phase_t  row_phase;
  phase_t  col_phase;
  col_t    oc;
  sample_t row_run_max;

  logic    s_acc;
  logic    cfg_acc;
  logic    restart;
  logic    last_col;
  logic    last_row;
  logic    col_wrap;
  logic    row_wrap;
  logic    h_end;
  logic    v_end;
  sample_t sample;
  sample_t run_max_next;

  stage_t  s1;
  logic    s1_go;
  logic    fwd;
  sample_t fwd_data;
  logic [SAMPLE_W-1:0] rd_data;
  sample_t old_max;
  sample_t new_max;

  assign h_eff = clamp_dim(num_rows, TOP_HEIGHT);
  assign w_eff = clamp_dim(num_cols, TOP_WIDTH);
  assign p_eff = clamp_pool(win_size);

  // ---------------------------------------------------------------------------
  // Configuration. Always ready; only listed registers restart the map.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign restart   = cfg_acc && (cfg_index == REG_NUM_ROWS ||
                                 cfg_index == REG_NUM_COLS ||
                                 cfg_index == REG_WIN_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= DIM_W'(4);
      num_cols <= DIM_W'(5);
      win_size <= POOL_W'(2);
    end else if (cfg_acc) begin
      case (reg_idx_t'(cfg_index))
        REG_NUM_ROWS: num_rows <= cfg_data;
        REG_NUM_COLS: num_cols <= cfg_data;
        REG_WIN_SIZE: win_size <= cfg_data[POOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position tracking, row-segment maximum and line-store read.
  // ---------------------------------------------------------------------------
  assign s1_go    = s1.valid && (!s1.emit || !m_tvalid || m_tready);
  assign s_tready = !s1.valid || s1_go;
  assign s_acc    = s_tvalid & s_tready;
  assign sample   = sample_t'(s_tdata);

  assign last_col = ({1'b0, col_index} + DIM_W'(1)) >= w_eff;
  assign last_row = ({1'b0, row_index} + DIM_W'(1)) >= h_eff;
  assign col_wrap = ({1'b0, col_phase} + POOL_W'(1)) >= p_eff;
  assign row_wrap = ({1'b0, row_phase} + POOL_W'(1)) >= p_eff;
  assign h_end    = last_col || col_wrap;
  assign v_end    = last_row || row_wrap;

  assign run_max_next = (col_phase == '0 || sample > row_run_max) ? sample : row_run_max;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_index   <= '0;
      col_index   <= '0;
      row_phase   <= '0;
      col_phase   <= '0;
      oc          <= '0;
      row_run_max <= '0;
    end else if (s_acc) begin
      row_run_max <= run_max_next;
      if (last_col) begin
        col_index <= '0;
        col_phase <= '0;
        oc        <= '0;
        if (last_row) begin
          row_index <= '0;
          row_phase <= '0;
        end else begin
          row_index <= row_index + ROW_W'(1);
          row_phase <= row_wrap ? '0 : row_phase + PH_W'(1);
        end
      end else begin
        col_index <= col_index + COL_W'(1);
        if (col_wrap) begin
          col_phase <= '0;
          oc        <= oc + COL_W'(1);
        end else begin
          col_phase <= col_phase + PH_W'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: compare with the stored column maximum and write it back.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (s_acc) begin
      s1.valid <= 1'b1;
    end else if (s1_go) begin
      s1.valid <= 1'b0;
    end
    if (s_acc) begin
      s1.h_end     <= h_end;
      s1.emit      <= h_end && v_end;
      s1.row_first <= (row_phase == '0);
      s1.last      <= last_row && last_col;
      s1.oc        <= oc;
      s1.run_max   <= run_max_next;
      // The write leaving stage 1 in this cycle is not yet in the read data.
      fwd          <= s1_go && s1.h_end && (s1.oc == oc);
      fwd_data     <= new_max;
    end
  end

  mxp_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (SAMPLE_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_go && s1.h_end),
    .wr_addr (s1.oc),
    .wr_data (new_max),
    .rd_en   (s_acc && h_end),
    .rd_addr (oc),
    .rd_data (rd_data)
  );

  assign old_max = fwd ? fwd_data : sample_t'(rd_data);
  assign new_max = (s1.row_first || s1.run_max > old_max) ? s1.run_max : old_max;

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go && s1.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1.emit) begin
      m_tdata <= new_max;
      m_tlast <= s1.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1.valid && s1.emit && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while the read stage is stalled");

  a_map_wraps: assert property (@(posedge clk) disable iff (rst)
    (s_acc && last_col && last_row) |=> (row_index == '0 && col_index == '0))
    else $error("position did not return to the map origin");

  a_phase_in_window: assert property (@(posedge clk) disable iff (rst)
    (s_acc && !restart) |=> ({1'b0, col_phase} < p_eff && {1'b0, row_phase} < p_eff))
    else $error("window phase beyond the pool size");

  a_write_on_go: assert property (@(posedge clk) disable iff (rst)
    (s1.valid && !s1_go) |=> (s1.valid && $stable(s1.oc)))
    else $error("stalled read stage lost its entry");

endmodule

FILE: sv/mxp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mxp_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
// A queue of map samples feeds a driver that offers them on the input stream
// with random gaps. Each sample transfer is run through a local pooling
// predictor, which keeps its own line of column maxima and its own position
// counters. Every window it completes is queued as an expected output. A
// monitor compares each output transfer against the oldest expected window,
// both value and last flag. The receiver stalls at random and, once, holds
// off for a long stretch so that the block backs up into its input.
// Configuration is written only while the block is drained: first a short
// directed map, then edge-sized and larger maps, then random small maps.
// ----------------------------------------------------------------------------
module tb_top;
  import mxp_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 600000;
  // Read stage and output register after a sample transfer, with margin.
  localparam int PIPE_SETTLE  = 4;
  localparam int LONG_HOLD    = 300;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 320;

  typedef struct packed {
    sample_t value;
    logic    done;
  } window_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;
  logic                m_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [DIM_W-1:0]    cfg_data  = '0;

  max_pool_2d_stream dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Samples waiting to be offered, and windows waiting to come out.
  sample_t        sample_queue[$];
  window_result_t pending_windows[$];

  int samples_queued   = 0;
  int samples_taken    = 0;
  int windows_seen     = 0;
  int cfg_writes_taken = 0;
  int failures         = 0;
  int cycle_count      = 0;

  // Transfers seen at the last rising edge, for the falling-edge drivers.
  logic took_sample = 1'b0;
  logic took_result = 1'b0;

  // Idling style of each side, switched per phase by the stimulus.
  bit sender_bursty   = 1'b0;
  bit receiver_bursty = 1'b0;
  int holds_requested = 0;

  // --------------------------------------------------------------------------
  // Pooling predictor state: raw register bits, line of column maxima and
  // the position of the next sample in the map and within its window.
  // --------------------------------------------------------------------------
  dim_t    pred_height = DIM_W'(4);
  dim_t    pred_width  = DIM_W'(5);
  pool_t   pred_pool   = POOL_W'(2);
  sample_t column_max [MAX_WIDTH];
  sample_t run_max     = '0;
  int      row_pos     = 0;
  int      col_pos     = 0;
  int      row_phase   = 0;
  int      col_phase   = 0;

  // A zero register acts as one; anything above the top acts as the top.
  function automatic int clamp_to(int v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function void restart_position();
    row_pos   = 0;
    col_pos   = 0;
    row_phase = 0;
    col_phase = 0;
    run_max   = '0;
  endfunction

  // Fold one sample into the running maxima and queue the window it closes.
  function void pool_predict(sample_t s);
    int             h;
    int             w;
    int             p;
    int             oc;
    bit             last_col;
    bit             last_row;
    window_result_t r;
    h = clamp_to(pred_height, MAX_HEIGHT);
    w = clamp_to(pred_width, MAX_WIDTH);
    p = clamp_to(pred_pool, MAX_POOL);
    last_col = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);

    if (col_phase == 0 || s > run_max) run_max = s;

    // The sample ends its segment of the window row, either at the window
    // edge or at the right edge of the map.
    if (last_col || col_phase + 1 >= p) begin
      oc = (col_pos / p) % MAX_WIDTH;
      if (row_phase == 0 || run_max > column_max[oc]) column_max[oc] = run_max;
      if (last_row || row_phase + 1 >= p) begin
        r.value = column_max[oc];
        r.done  = last_row && last_col;
        pending_windows.insert(pending_windows.size(), r);
      end
    end

    if (last_col) begin
      col_pos   = 0;
      col_phase = 0;
      if (last_row) begin
        row_pos   = 0;
        row_phase = 0;
      end else begin
        row_pos++;
        row_phase = (row_phase + 1 >= p) ? 0 : row_phase + 1;
      end
    end else begin
      col_pos++;
      col_phase = (col_phase + 1 >= p) ? 0 : col_phase + 1;
    end
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endfunction

  function automatic int draw_wait(bit bursty);
    return bursty ? 0 : $urandom_range(0, 11);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: all transfers are observed at the rising edge. Configuration
  // writes update the predictor, sample transfers run the predictor, and
  // output transfers are checked against the oldest expected window.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    window_result_t want;
    took_sample <= s_tvalid && s_tready && !rst;
    took_result <= m_tvalid && m_tready && !rst;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes_taken++;
        case (reg_idx_t'(cfg_index))
          REG_NUM_ROWS: begin
            pred_height = cfg_data;
            restart_position();
          end
          REG_NUM_COLS: begin
            pred_width = cfg_data;
            restart_position();
          end
          REG_WIN_SIZE: begin
            pred_pool = cfg_data[POOL_W-1:0];
            restart_position();
          end
          default: begin
            // Writes beyond the register list leave the map where it is.
          end
        endcase
      end
      if (s_tvalid && s_tready) begin
        pool_predict(s_tdata);
        samples_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (pending_windows.size() == 0) begin
          note_failure($sformatf("output %0d with no window pending: value %0d last %0b",
                                 windows_seen, $signed(m_tdata), m_tlast));
        end else begin
          want = pending_windows.pop_front();
          if (m_tdata !== want.value || m_tlast !== want.done)
            note_failure($sformatf("output %0d: expected value %0d last %0b, got %0d last %0b",
                                   windows_seen, $signed(want.value), want.done,
                                   $signed(m_tdata), m_tlast));
        end
        windows_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sample driver: offers queued samples at the falling edge. After each
  // transfer it waits a drawn number of cycles before the next offer, so a
  // zero draw keeps tvalid high across back-to-back transfers.
  // --------------------------------------------------------------------------
  logic    drv_valid;
  sample_t drv_data;
  int      send_gap = 0;

  always @(negedge clk) begin
    drv_valid = s_tvalid;
    drv_data  = s_tdata;
    if (rst) begin
      drv_valid = 1'b0;
      send_gap  = 0;
    end else begin
      if (took_sample) drv_valid = 1'b0;
      if (!drv_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_queue.size() != 0) begin
          drv_valid = 1'b1;
          drv_data  = sample_queue.pop_front();
          send_gap  = draw_wait(sender_bursty);
        end
      end
    end
    s_tvalid <= drv_valid;
    s_tdata  <= drv_data;
  end

  // --------------------------------------------------------------------------
  // Receiver: stalls a drawn number of cycles after each output transfer.
  // On request it also holds off for a long stretch, counted here, while the
  // driver keeps offering samples.
  // --------------------------------------------------------------------------
  logic rcv_ready;
  int   hold_left    = 0;
  int   stall_left   = 0;
  int   holds_served = 0;

  always @(negedge clk) begin
    if (rst) begin
      rcv_ready  = 1'b0;
      hold_left  = 0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      rcv_ready = 1'b0;
    end else if (holds_served != holds_requested) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      rcv_ready = 1'b0;
    end else begin
      if (took_result) stall_left = draw_wait(receiver_bursty);
      if (stall_left > 0) begin
        stall_left--;
        rcv_ready = 1'b0;
      end else begin
        rcv_ready = 1'b1;
      end
    end
    m_tready <= rcv_ready;
  end

  // A run that stops making progress ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic queue_sample(sample_t s);
    sample_queue.insert(sample_queue.size(), s);
    samples_queued++;
  endtask

  // Mostly uniform values, with the extremes, zero and minus one mixed in.
  function automatic sample_t draw_sample();
    sample_t s;
    case ($urandom_range(0, 9))
      0:       s = 16'h8000;
      1:       s = 16'h7FFF;
      2:       s = 16'h0000;
      3:       s = 16'hFFFF;
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  task automatic queue_random_samples(int n);
    repeat (n) queue_sample(draw_sample());
  endtask

  // Every sample has been taken and every window has come out; allow the
  // pipeline to settle, since a trailing sample may close no window.
  task automatic wait_idle();
    while (samples_taken != samples_queued || pending_windows.size() != 0)
      @(negedge clk);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, dim_t value);
    int target;
    target = cfg_writes_taken + 1;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (cfg_writes_taken != target);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(dim_t h, dim_t w, dim_t p);
    write_register(REG_NUM_ROWS, h);
    write_register(REG_NUM_COLS, w);
    write_register(REG_WIN_SIZE, p);
  endtask

  function automatic dim_t pick_dim();
    dim_t d;
    d = ($urandom_range(0, 15) == 0) ? dim_t'(0) : dim_t'($urandom_range(1, 12));
    return d;
  endfunction

  // Effective number of samples in one map under the predictor's settings.
  function automatic int map_samples();
    return clamp_to(pred_height, MAX_HEIGHT) * clamp_to(pred_width, MAX_WIDTH);
  endfunction

  // A 4 x 5 map for the reset settings (pool size 2). The top-left window and
  // the bottom-right window hold only the most negative value; the others hold mixed values.
  int directed_map [20] = '{
    -32768, -32768,    100,  32767,     -1,
    -32768, -32768,  32767,     -5,      0,
         1,     -1,   4660, -32768, -32768,
         0,      2, -32768,  32766, -32768
  };

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int   random_items;
    int   maps;
    int   n;
    dim_t h;
    dim_t w;
    dim_t p;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed: one full map under the reset settings.
    foreach (directed_map[i]) queue_sample(sample_t'(directed_map[i]));
    wait_idle();

    // A write past the register list must not restart the map, while a
    // write to a real register does, with high data bits ignored for pool.
    queue_random_samples(3);
    wait_idle();
    write_register(REG_UNUSED, dim_t'(11'h7FF));
    queue_random_samples(4);
    wait_idle();
    write_register(REG_WIN_SIZE, dim_t'(11'h7F2));
    queue_random_samples(20);
    wait_idle();

    // Edge sizes: single-sample maps, zero registers, and register values
    // above the top. Only the start of the tall and the wide map is sent.
    configure(11'd1, 11'd1, 11'd1);
    queue_random_samples(3);
    wait_idle();
    configure(11'd0, 11'd0, 11'd0);
    queue_random_samples(2);
    wait_idle();
    configure(11'd2047, 11'd1, 11'd15);
    queue_random_samples(64);
    wait_idle();
    configure(11'd1, 11'd2047, 11'd0);
    queue_random_samples(48);
    wait_idle();

    // Long receiver hold while the sender streams without gaps, so the
    // block backs up and stalls its input.
    sender_bursty = 1'b1;
    configure(11'd12, 11'd12, 11'd0);
    holds_requested++;
    queue_random_samples(map_samples());
    wait_idle();
    sender_bursty = 1'b0;

    configure(11'd8, 11'd8, 11'd8);
    queue_random_samples(map_samples());
    wait_idle();
    configure(11'd7, 11'd9, 11'd3);
    queue_random_samples(map_samples());
    wait_idle();
    configure(11'd5, 11'd3, 11'd4);
    queue_random_samples(map_samples());
    wait_idle();

    // Random small maps: whole maps mostly, with some cut short.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      sender_bursty   = ($urandom_range(0, 3) == 0);
      receiver_bursty = ($urandom_range(0, 3) == 0);
      h = pick_dim();
      w = pick_dim();
      p = dim_t'({$urandom_range(0, 127), 4'($urandom_range(0, 15))});
      configure(h, w, p);
      if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, dim_t'($urandom));
      maps = $urandom_range(1, 3);
      repeat (maps) begin
        n = map_samples();
        if (n > 1 && $urandom_range(0, 7) == 0) n = $urandom_range(1, n - 1);
        queue_random_samples(n);
        random_items += n;
      end
      wait_idle();
    end

    wait_idle();
    if (failures == 0 && pending_windows.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/mxp_pkg.sv
sv/mxp_ram.sv
sv/max_pool_2d_stream.sv
verif/tb_top.sv
